FILE: design/playfair_digraph_encrypt_core_macros.svh
// ----------------------------------------------------------------------------
// Playfair digraph encryptor assertion macros
// Shared concurrent assertion wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_DIGRAPH_ENCRYPT_CORE_MACROS_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPT_CORE_MACROS_SVH

// assertion that is off while reset is held
`define PFE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pfe assertion failed");

// assertion that is also checked during reset
`define PFE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("pfe assertion failed");

`endif

FILE: design/pfe_pkg.sv
// ----------------------------------------------------------------------------
// Playfair digraph encryptor package
// Types and constants shared by the key square lanes, merge and top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfe_pkg;

    localparam int KEY_DIM = 5;
    localparam int CODE_W  = 5;
    localparam int ROW_W   = KEY_DIM * CODE_W;
    localparam int IDX_W   = 3;

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef row_t              key_sq_t [KEY_DIM];

    localparam row_t KEY_ROW_0_RST = 25'd17839564;
    localparam row_t KEY_ROW_1_RST = 25'd3203298;
    localparam row_t KEY_ROW_2_RST = 25'd10754212;
    localparam row_t KEY_ROW_3_RST = 25'd20529643;
    localparam row_t KEY_ROW_4_RST = 25'd26991284;

    localparam idx_t LAST_IDX = idx_t'(KEY_DIM - 1);

    // per-row search result for both letters of a digraph
    typedef struct packed {
        logic found_a;
        idx_t col_a;
        logic found_b;
        idx_t col_b;
    } lane_hit_t;

    function automatic code_t cell_of(row_t row, idx_t col);
        return row[col*CODE_W +: CODE_W];
    endfunction

    function automatic idx_t next_idx(idx_t i);
        return (i == LAST_IDX) ? '0 : idx_t'(i + idx_t'(1));
    endfunction

endpackage

FILE: design/pfe_if.sv
// ----------------------------------------------------------------------------
// Playfair digraph encryptor channels
// Valid/ready channels for plaintext digraphs and ciphertext results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pfe_in_if;
    logic           valid;
    logic           ready;
    pfe_pkg::code_t letter_first;
    pfe_pkg::code_t letter_second;

    modport source (output valid, output letter_first, output letter_second, input ready);
    modport sink   (input valid, input letter_first, input letter_second, output ready);
endinterface

interface pfe_out_if;
    logic           valid;
    logic           ready;
    pfe_pkg::code_t cipher_first;
    pfe_pkg::code_t cipher_second;
    logic           letter_missing;

    modport source (output valid, output cipher_first, output cipher_second,
                    output letter_missing, input ready);
    modport sink   (input valid, input cipher_first, input cipher_second,
                    input letter_missing, output ready);
endinterface

FILE: design/pfe_lane.sv
// ----------------------------------------------------------------------------
// Playfair key square row lane
// Searches one row of the key square for both digraph letters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfe_lane (
    input  pfe_pkg::row_t      row,
    input  pfe_pkg::code_t     letter_a,
    input  pfe_pkg::code_t     letter_b,
    output pfe_pkg::lane_hit_t hit
);

    always_comb
    begin
        hit = '0;
        // last match in column order wins
        for (int c = 0; c < pfe_pkg::KEY_DIM; c++)
        begin
            if (row[c*pfe_pkg::CODE_W +: pfe_pkg::CODE_W] == letter_a)
            begin
                hit.found_a = 1'b1;
                hit.col_a   = pfe_pkg::idx_t'(c);
            end
            if (row[c*pfe_pkg::CODE_W +: pfe_pkg::CODE_W] == letter_b)
            begin
                hit.found_b = 1'b1;
                hit.col_b   = pfe_pkg::idx_t'(c);
            end
        end
    end

endmodule

FILE: design/pfe_merge.sv
// ----------------------------------------------------------------------------
// Playfair lane merge and substitution
// Picks the winning row per letter and applies the row, column or
// rectangle rule; flags letter_missing when a letter is not found.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfe_merge (
    input  pfe_pkg::key_sq_t   key_sq,
    input  pfe_pkg::lane_hit_t hits [pfe_pkg::KEY_DIM],
    output pfe_pkg::code_t     cipher_first,
    output pfe_pkg::code_t     cipher_second,
    output logic               letter_missing
);

    logic          fa;
    logic          fb;
    pfe_pkg::idx_t r1;
    pfe_pkg::idx_t c1;
    pfe_pkg::idx_t r2;
    pfe_pkg::idx_t c2;

    always_comb
    begin
        fa = 1'b0;
        fb = 1'b0;
        r1 = '0;
        c1 = '0;
        r2 = '0;
        c2 = '0;
        // later rows override earlier ones
        for (int r = 0; r < pfe_pkg::KEY_DIM; r++)
        begin
            if (hits[r].found_a)
            begin
                fa = 1'b1;
                r1 = pfe_pkg::idx_t'(r);
                c1 = hits[r].col_a;
            end
            if (hits[r].found_b)
            begin
                fb = 1'b1;
                r2 = pfe_pkg::idx_t'(r);
                c2 = hits[r].col_b;
            end
        end
    end

    always_comb
    begin
        letter_missing = 1'b0;
        if (!fa || !fb)
        begin
            cipher_first   = '0;
            cipher_second  = '0;
            letter_missing = 1'b1;
        end
        else if (r1 == r2)
        begin
            cipher_first  = pfe_pkg::cell_of(key_sq[r1], pfe_pkg::next_idx(c1));
            cipher_second = pfe_pkg::cell_of(key_sq[r2], pfe_pkg::next_idx(c2));
        end
        else if (c1 == c2)
        begin
            cipher_first  = pfe_pkg::cell_of(key_sq[pfe_pkg::next_idx(r1)], c1);
            cipher_second = pfe_pkg::cell_of(key_sq[pfe_pkg::next_idx(r2)], c2);
        end
        else
        begin
            cipher_first  = pfe_pkg::cell_of(key_sq[r1], c2);
            cipher_second = pfe_pkg::cell_of(key_sq[r2], c1);
        end
    end

endmodule

FILE: design/playfair_digraph_encrypt_core.sv
// ----------------------------------------------------------------------------
// Playfair digraph encryptor core
// Five row lanes search the key square in parallel; a merge stage applies
// the Playfair substitution.
// ----------------------------------------------------------------------------
// Pipeline: lane register, then output register, from accepted item to valid result.
// Throughput: 1 item per cycle unless out_ch stalls; an empty lane register still takes an item.
// Reset: pipeline emptied, key square loaded with the default square.
`timescale 1ns / 1ps

module playfair_digraph_encrypt_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  pfe_pkg::idx_t       cfg_index,
    input  pfe_pkg::row_t       cfg_wdata,
    pfe_in_if.sink              in_ch,
    pfe_out_if.source           out_ch
);

    pfe_pkg::key_sq_t   key_reg;
    pfe_pkg::lane_hit_t lane_hit   [pfe_pkg::KEY_DIM];
    pfe_pkg::lane_hit_t hit_reg    [pfe_pkg::KEY_DIM];
    logic               s1_valid_reg;
    logic               out_valid_reg;
    pfe_pkg::code_t     cf_next;
    pfe_pkg::code_t     cs_next;
    logic               miss_next;
    pfe_pkg::code_t     cf_reg;
    pfe_pkg::code_t     cs_reg;
    logic               miss_reg;
    logic               out_move;
    logic               s1_move;

    assign out_move = !out_valid_reg || out_ch.ready;
    assign s1_move  = !s1_valid_reg || out_move;

    assign in_ch.ready           = s1_move;
    assign out_ch.valid          = out_valid_reg;
    assign out_ch.cipher_first   = cf_reg;
    assign out_ch.cipher_second  = cs_reg;
    assign out_ch.letter_missing = miss_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg[0] <= pfe_pkg::KEY_ROW_0_RST;
            key_reg[1] <= pfe_pkg::KEY_ROW_1_RST;
            key_reg[2] <= pfe_pkg::KEY_ROW_2_RST;
            key_reg[3] <= pfe_pkg::KEY_ROW_3_RST;
            key_reg[4] <= pfe_pkg::KEY_ROW_4_RST;
        end
        else if (cfg_we && (cfg_index <= pfe_pkg::LAST_IDX))
        begin
            key_reg[cfg_index] <= cfg_wdata;
        end
    end

    for (genvar g = 0; g < pfe_pkg::KEY_DIM; g++)
    begin : g_lane
        pfe_lane u_lane (
            .row      (key_reg[g]),
            .letter_a (in_ch.letter_first),
            .letter_b (in_ch.letter_second),
            .hit      (lane_hit[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_move)
            begin
                s1_valid_reg <= in_ch.valid;
            end
            if (out_move)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && in_ch.valid)
        begin
            hit_reg <= lane_hit;
        end
        if (out_move && s1_valid_reg)
        begin
            cf_reg   <= cf_next;
            cs_reg   <= cs_next;
            miss_reg <= miss_next;
        end
    end

    pfe_merge u_merge (
        .key_sq         (key_reg),
        .hits           (hit_reg),
        .cipher_first   (cf_next),
        .cipher_second  (cs_next),
        .letter_missing (miss_next)
    );

endmodule

FILE: design/pfe_checker.sv
// ----------------------------------------------------------------------------
// Playfair digraph encryptor checker
// Port-level assertions on the encryptor core, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "playfair_digraph_encrypt_core_macros.svh"

module pfe_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input pfe_pkg::code_t cipher_first,
    input pfe_pkg::code_t cipher_second,
    input logic           letter_missing
);

    logic [2*pfe_pkg::CODE_W:0] out_word;
    logic                       cipher_zero;

    assign out_word    = {cipher_first, cipher_second, letter_missing};
    assign cipher_zero = (cipher_first == '0) && (cipher_second == '0);

    `PFE_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_word))
    `PFE_ASSERT(a_miss_zero, clk, rst_n, out_valid && letter_missing |-> cipher_zero)
    `PFE_ASSERT(a_latency, clk, rst_n, (in_valid && in_ready) ##1 out_ready |=> out_valid)
    `PFE_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |-> !out_valid)

endmodule

bind playfair_digraph_encrypt_core pfe_checker u_pfe_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .cipher_first   (out_ch.cipher_first),
    .cipher_second  (out_ch.cipher_second),
    .letter_missing (out_ch.letter_missing)
);
